// ===== src/frt_pkg.sv =====
package frt_pkg;

  localparam int unsigned CmdW    = 2;
  localparam int unsigned StatusW = 4;
  localparam int unsigned LenW    = 20;
  localparam int unsigned CountW  = 9;
  localparam int unsigned AgedW   = 5;
  localparam int unsigned SumW    = 16;
  localparam int unsigned TimeW   = 32;
  localparam int unsigned KeyW    = 80;

  typedef enum logic [CmdW-1:0] {
    CMD_FRAG  = 2'd0,
    CMD_TICK  = 2'd1,
    CMD_FLUSH = 2'd2,
    CMD_NONE  = 2'd3
  } cmd_e;

  typedef enum logic [StatusW-1:0] {
    ST_ACCEPTED      = 4'd0,
    ST_DUPLICATE     = 4'd1,
    ST_FIRST_MISSING = 4'd2,
    ST_TABLE_FULL    = 4'd3,
    ST_REASSEMBLED   = 4'd4,
    ST_SUM_FAIL      = 4'd5,
    ST_NO_ENTRY      = 4'd6,
    ST_TICK          = 4'd7,
    ST_FLUSHED       = 4'd8
  } status_e;

  localparam logic [LenW-1:0]   LenMax   = '1;
  localparam logic [CountW-1:0] CountMax = 9'd256;
  localparam logic [SumW-1:0]   SumMax   = '1;

  // One stored context: key, counters and deadline.
  typedef struct packed {
    logic [KeyW-1:0]   key;
    logic [CountW-1:0] count;
    logic [SumW-1:0]   id_sum;
    logic [LenW-1:0]   length;
    logic [TimeW-1:0]  deadline;
  } slot_t;

  localparam int unsigned SlotW = $bits(slot_t);

endpackage

// ===== src/frt_ram.sv =====
module frt_ram #(
  parameter int unsigned Width = 8,
  parameter int unsigned Depth = 16
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(Depth)-1:0] waddr_i,
  input  logic [Width-1:0]         wdata_i,
  input  logic [$clog2(Depth)-1:0] raddr_i,
  output logic [Width-1:0]         rdata_o
);

  logic [Width-1:0] mem_q [Depth];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_o <= mem_q[raddr_i];
  end

endmodule

// ===== src/fragment_reassembly_tracker.sv =====
// Fragment reassembly tracker. Pulse start_i with an arrival, tick or flush
// command while busy_o is low; exactly one result follows, shown for a single
// cycle with result_valid_o, and it cannot be stalled. Contexts sit in a RAM
// with one registered read port, walked one slot at a time by a small
// sequencer, which takes no new command until its result is out. Ticks and
// arrivals that match no context walk every slot; an arrival that matches the
// context in slot k stops the walk there. Flush and unknown commands answer on
// the next cycle and never raise busy_o.
// The valid bits live in flip-flops and are cleared by reset and flush.
module fragment_reassembly_tracker #(
  parameter int unsigned ENTRIES = 16
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  // command channel
  input  logic        start_i,
  output logic        busy_o,
  input  logic [1:0]  cmd_i,
  input  logic [15:0] msg_type_i,
  input  logic [15:0] message_id_i,
  input  logic [7:0]  fragment_id_i,
  input  logic        last_flag_i,
  input  logic [47:0] origin_mac_i,
  input  logic [10:0] frag_len_i,
  // results
  output logic        result_valid_o,
  output logic [3:0]  status_o,
  output logic [19:0] total_length_o,
  output logic [8:0]  fragment_count_o,
  output logic [4:0]  aged_count_o,
  // configuration
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [1:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready
);

  localparam int unsigned IdxW = $clog2(ENTRIES);
  localparam int unsigned CntW = $clog2(ENTRIES + 1);

  typedef enum logic [5:0] {
    S_IDLE  = 6'b000001,
    S_READ  = 6'b000010,  // address issued, wait for data
    S_CHECK = 6'b000100,  // compare one slot
    S_UPD   = 6'b001000,  // read back matched slot
    S_WRITE = 6'b010000,  // write joined or new slot, finish
    S_DONE  = 6'b100000
  } state_e;

  state_e state_q, state_d;

  logic [15:0]           ageing_q;
  logic [31:0]           now_q;
  logic [ENTRIES-1:0]    valid_q;
  logic [IdxW-1:0]       idx_q;
  logic                  hit_q, free_q;
  logic [IdxW-1:0]       hit_idx_q, free_idx_q;
  logic [CntW-1:0]       aged_q;

  logic [1:0]            cmd_q;
  logic [79:0]           key_q;
  logic [7:0]            fid_q;
  logic                  last_q;
  logic [10:0]           flen_q;

  logic                  we;
  logic [IdxW-1:0]       waddr, raddr;
  frt_pkg::slot_t        wslot, rslot;

  frt_ram #(.Width(frt_pkg::SlotW), .Depth(ENTRIES)) u_ram (
    .clk_i   (clk_i),
    .we_i    (we),
    .waddr_i (waddr),
    .wdata_i (wslot),
    .raddr_i (raddr),
    .rdata_o (rslot)
  );

  // config port
  assign pready = 1'b1;
  assign prdata = (paddr == 2'd0) ? {16'd0, ageing_q} : 32'd0;
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ageing_q <= 16'd1000;
    end else if (psel && penable && pwrite && paddr == 2'd0) begin
      ageing_q <= pwdata[15:0];
    end
  end

  assign busy_o = (state_q != S_IDLE);
  // scan address, except in S_UPD where the matched slot is read back
  assign raddr  = (state_q == S_UPD) ? hit_idx_q : idx_q;

  // deadline reached check for the slot under scan
  logic [31:0] dl_diff;
  logic        expired, slot_hit;
  assign dl_diff  = rslot.deadline - now_q;
  assign expired  = (dl_diff == 32'd0) || dl_diff[31];
  assign slot_hit = valid_q[idx_q] && (rslot.key == key_q);

  // join arithmetic on the matched slot
  logic [20:0] len_sum;
  logic [16:0] id_sum;
  logic [15:0] sum_new;
  logic [8:0]  cnt_new;
  logic [19:0] len_new;
  assign len_sum = {1'b0, rslot.length} + 21'(flen_q);
  assign len_new = len_sum[20] ? frt_pkg::LenMax : len_sum[19:0];
  assign id_sum  = {1'b0, rslot.id_sum} + 17'(fid_q);
  assign sum_new = id_sum[16] ? frt_pkg::SumMax : id_sum[15:0];
  assign cnt_new = (rslot.count < frt_pkg::CountMax) ? rslot.count + 9'd1 : rslot.count;

  logic [15:0] fid_prod;
  assign fid_prod = 16'(fid_q) * (16'(fid_q) + 16'd1);

  logic last_idx;
  assign last_idx = (idx_q == IdxW'(ENTRIES - 1));

  logic        res_v_d;
  logic [3:0]  res_st_d;
  logic [19:0] res_len_d;
  logic [8:0]  res_cnt_d;
  logic [4:0]  res_aged_d;

  always_comb begin
    state_d    = state_q;
    we         = 1'b0;
    waddr      = hit_idx_q;
    wslot      = rslot;
    res_v_d    = 1'b0;
    res_st_d   = frt_pkg::ST_NO_ENTRY;
    res_len_d  = '0;
    res_cnt_d  = '0;
    res_aged_d = '0;
    unique case (state_q)
      S_IDLE: begin
        if (start_i) begin
          unique case (frt_pkg::cmd_e'(cmd_i))
            frt_pkg::CMD_FRAG, frt_pkg::CMD_TICK: state_d = S_READ;
            frt_pkg::CMD_FLUSH: begin
              res_v_d  = 1'b1;
              res_st_d = frt_pkg::ST_FLUSHED;
            end
            default: res_v_d = 1'b1;
          endcase
        end
      end
      S_READ: state_d = S_CHECK;
      S_CHECK: begin
        if (last_idx || (cmd_q == frt_pkg::CMD_FRAG && slot_hit)) begin
          state_d = S_UPD;
        end else begin
          state_d = S_READ;
        end
      end
      S_UPD: state_d = S_WRITE;  // hit slot read issued
      S_WRITE: begin
        state_d = S_DONE;
        res_v_d = 1'b1;
        if (cmd_q == frt_pkg::CMD_TICK) begin
          res_st_d   = frt_pkg::ST_TICK;
          res_aged_d = 5'(aged_q);
        end else if (hit_q) begin
          if (fid_q == 8'd0) begin
            res_st_d = frt_pkg::ST_DUPLICATE;
          end else begin
            we           = 1'b1;
            wslot.length = len_new;
            wslot.count  = cnt_new;
            wslot.id_sum = sum_new;
            if (last_q) begin
              res_st_d  = (fid_prod[15:0] == {sum_new[14:0], 1'b0} && !sum_new[15])
                          ? frt_pkg::ST_REASSEMBLED : frt_pkg::ST_SUM_FAIL;
              res_len_d = len_new;
              res_cnt_d = cnt_new;
            end else begin
              res_st_d = frt_pkg::ST_ACCEPTED;
            end
          end
        end else if (fid_q != 8'd0) begin
          res_st_d = frt_pkg::ST_FIRST_MISSING;
        end else if (!free_q) begin
          res_st_d = frt_pkg::ST_TABLE_FULL;
        end else begin
          we             = 1'b1;
          waddr          = free_idx_q;
          wslot.key      = key_q;
          wslot.count    = 9'd1;
          wslot.id_sum   = '0;
          wslot.length   = 20'(flen_q);
          wslot.deadline = now_q + 32'(ageing_q);
          if (last_q) begin
            res_st_d  = frt_pkg::ST_REASSEMBLED;
            res_len_d = 20'(flen_q);
            res_cnt_d = 9'd1;
          end else begin
            res_st_d = frt_pkg::ST_ACCEPTED;
          end
        end
      end
      S_DONE: state_d = S_IDLE;
      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q        <= S_IDLE;
      valid_q        <= '0;
      now_q          <= '0;
      idx_q          <= '0;
      hit_q          <= 1'b0;
      free_q         <= 1'b0;
      hit_idx_q      <= '0;
      free_idx_q     <= '0;
      aged_q         <= '0;
      result_valid_o <= 1'b0;
    end else begin
      state_q        <= state_d;
      result_valid_o <= res_v_d;
      if (state_q == S_IDLE && start_i) begin
        idx_q  <= '0;
        hit_q  <= 1'b0;
        free_q <= 1'b0;
        aged_q <= '0;
        if (cmd_i == frt_pkg::CMD_TICK) now_q <= now_q + 32'd1;
        if (cmd_i == frt_pkg::CMD_FLUSH) valid_q <= '0;
      end
      if (state_q == S_CHECK) begin
        if (!last_idx) idx_q <= idx_q + IdxW'(1);
        if (cmd_q == frt_pkg::CMD_TICK) begin
          if (valid_q[idx_q] && expired) begin
            valid_q[idx_q] <= 1'b0;
            aged_q         <= aged_q + CntW'(1);
          end
        end else begin
          if (slot_hit) begin
            hit_q     <= 1'b1;
            hit_idx_q <= idx_q;
          end
          if (!valid_q[idx_q] && !free_q) begin
            free_q     <= 1'b1;
            free_idx_q <= idx_q;
          end
        end
      end
      if (state_q == S_WRITE && cmd_q == frt_pkg::CMD_FRAG) begin
        if (hit_q && fid_q != 8'd0 && last_q) valid_q[hit_idx_q] <= 1'b0;
        if (!hit_q && fid_q == 8'd0 && free_q && !last_q) valid_q[free_idx_q] <= 1'b1;
      end
    end
  end

  // captured command and result registers
  always_ff @(posedge clk_i) begin
    if (state_q == S_IDLE && start_i) begin
      cmd_q  <= cmd_i;
      key_q  <= {msg_type_i, message_id_i, origin_mac_i};
      fid_q  <= fragment_id_i;
      last_q <= last_flag_i;
      flen_q <= frag_len_i;
    end
    status_o         <= res_st_d;
    total_length_o   <= res_len_d;
    fragment_count_o <= res_cnt_d;
    aged_count_o     <= res_aged_d;
  end

endmodule

// ===== verif/tb_fragment_reassembly_tracker.sv =====
`timescale 1ns / 100ps

module tb_fragment_reassembly_tracker;

  localparam int Slots = 16;
  localparam logic [1:0] AgeingAddr = 2'd0;  // register 0: ageing_ms

  // one expected result transaction
  typedef struct {
    frt_pkg::status_e status;
    logic [19:0]      total_len;
    logic [8:0]       frag_cnt;
    logic [4:0]       aged;
  } outcome_t;

  // reassembly key
  typedef struct packed {
    logic [15:0] mtype;
    logic [15:0] mid;
    logic [47:0] mac;
  } msg_key_t;

  logic        clk_i, rst_ni;
  logic        start_i;
  logic        busy_o;
  logic [1:0]  cmd_i;
  logic [15:0] msg_type_i, message_id_i;
  logic [7:0]  fragment_id_i;
  logic        last_flag_i;
  logic [47:0] origin_mac_i;
  logic [10:0] frag_len_i;
  logic        result_valid_o;
  logic [3:0]  status_o;
  logic [19:0] total_length_o;
  logic [8:0]  fragment_count_o;
  logic [4:0]  aged_count_o;
  logic        psel, penable, pwrite;
  logic [1:0]  paddr;
  logic [31:0] pwdata, prdata;
  logic        pready;

  fragment_reassembly_tracker uut (
    .clk_i, .rst_ni, .start_i, .busy_o, .cmd_i, .msg_type_i, .message_id_i,
    .fragment_id_i, .last_flag_i, .origin_mac_i, .frag_len_i,
    .result_valid_o, .status_o, .total_length_o, .fragment_count_o,
    .aged_count_o, .psel, .penable, .pwrite, .paddr, .pwdata, .prdata, .pready
  );

  // Shadow context table, mirrors the block's state.
  logic        ctx_valid [Slots];
  msg_key_t    ctx_key   [Slots];
  int unsigned ctx_count [Slots];
  int unsigned ctx_sum   [Slots];
  int unsigned ctx_len   [Slots];
  logic [31:0] ctx_deadline [Slots];
  logic [31:0] clock_ms;
  logic [15:0] ageing_ms;

  outcome_t pending_results[$];
  int n_sent, n_checked, n_errors;
  int n_reassembled, n_sum_fail, n_full, n_aged;
  bit gaps_on = 1;

  initial begin
    clk_i = 0;
    forever #5 clk_i = ~clk_i;
  end

  // safety net
  initial begin
    #20_000_000;
    $display("Timeout: %0d transactions sent, %0d checked", n_sent, n_checked);
    $display("Simulation FAILED");
    $finish;
  end

  task automatic report_mismatch(input string what);
    n_errors++;
    $display("[%0t] MISMATCH %s", $realtime, what);
  endtask

  // Compute the expected result of one transaction and advance the shadow table.
  function automatic outcome_t track_fragment(frt_pkg::cmd_e c, msg_key_t k,
                                              logic [7:0] fid, logic last,
                                              logic [10:0] flen);
    outcome_t r;
    int hit, free;
    logic [31:0] d;
    r = '{frt_pkg::ST_ACCEPTED, '0, '0, '0};
    hit = -1;
    free = -1;
    case (c)
      frt_pkg::CMD_TICK: begin
        clock_ms = clock_ms + 1;
        r.status = frt_pkg::ST_TICK;
        for (int i = 0; i < Slots; i++) begin
          if (ctx_valid[i]) begin
            d = ctx_deadline[i] - clock_ms;
            if (d == 0 || d[31]) begin
              ctx_valid[i] = 0;
              r.aged++;
            end
          end
        end
        return r;
      end
      frt_pkg::CMD_FLUSH: begin
        for (int i = 0; i < Slots; i++) ctx_valid[i] = 0;
        r.status = frt_pkg::ST_FLUSHED;
        return r;
      end
      frt_pkg::CMD_NONE: begin
        r.status = frt_pkg::ST_NO_ENTRY;
        return r;
      end
      default: ;
    endcase
    for (int i = Slots - 1; i >= 0; i--) begin
      if (ctx_valid[i] && ctx_key[i] == k) hit = i;
      if (!ctx_valid[i]) free = i;
    end
    if (fid == 0) begin
      if (hit >= 0) begin
        r.status = frt_pkg::ST_DUPLICATE;
        return r;
      end
      if (free < 0) begin
        r.status = frt_pkg::ST_TABLE_FULL;
        return r;
      end
      hit = free;
      ctx_valid[hit] = 1;
      ctx_key[hit] = k;
      ctx_count[hit] = 1;
      ctx_sum[hit] = 0;
      ctx_len[hit] = flen;
      ctx_deadline[hit] = clock_ms + ageing_ms;
    end else begin
      if (hit < 0) begin
        r.status = frt_pkg::ST_FIRST_MISSING;
        return r;
      end
      ctx_len[hit] = (ctx_len[hit] + flen > 20'hFFFFF) ? 20'hFFFFF : ctx_len[hit] + flen;
      if (ctx_count[hit] < 256) ctx_count[hit]++;
      ctx_sum[hit] = (ctx_sum[hit] + fid > 16'hFFFF) ? 16'hFFFF : ctx_sum[hit] + fid;
    end
    if (!last) return r;
    ctx_valid[hit] = 0;
    r.status = (fid * (fid + 1) == 2 * ctx_sum[hit]) ? frt_pkg::ST_REASSEMBLED
                                                     : frt_pkg::ST_SUM_FAIL;
    r.total_len = ctx_len[hit];
    r.frag_cnt = ctx_count[hit];
    return r;
  endfunction

  // Random idle burst ahead of a transaction; start drops only when idling.
  task automatic sender_gap();
    if (gaps_on && $urandom_range(0, 3) == 0) begin
      start_i <= 0;
      repeat ($urandom_range(1, 12)) @(posedge clk_i);
    end
  endtask

  // Send one transaction and wait for it to be taken. start stays high on
  // return so back-to-back transactions need no extra edge.
  task automatic send_item(frt_pkg::cmd_e c, msg_key_t k, logic [7:0] fid, logic last,
                           logic [10:0] flen);
    sender_gap();
    start_i       <= 1;
    cmd_i         <= c;
    msg_type_i    <= k.mtype;
    message_id_i  <= k.mid;
    fragment_id_i <= fid;
    last_flag_i   <= last;
    origin_mac_i  <= k.mac;
    frag_len_i    <= flen;
    forever begin
      @(negedge clk_i);
      if (!busy_o) break;
    end
    @(posedge clk_i);
    pending_results.push_back(track_fragment(c, k, fid, last, flen));
    n_sent++;
  endtask

  task automatic send_frag(msg_key_t k, logic [7:0] fid, logic last, logic [10:0] flen);
    send_item(frt_pkg::CMD_FRAG, k, fid, last, flen);
  endtask

  // Lower start, wait for every outstanding result, then let the block settle.
  task automatic drain_results();
    start_i <= 0;
    @(posedge clk_i);
    while (pending_results.size() != 0) @(posedge clk_i);
    repeat (40) @(posedge clk_i);
  endtask

  // APB write of ageing_ms, then read it back. Only called while drained.
  task automatic set_ageing(logic [15:0] v);
    psel <= 1; penable <= 0; pwrite <= 1; paddr <= AgeingAddr; pwdata <= {16'd0, v};
    @(posedge clk_i);
    penable <= 1;
    do @(negedge clk_i); while (!pready);
    @(posedge clk_i);
    ageing_ms = v;
    psel <= 1; penable <= 0; pwrite <= 0;
    @(posedge clk_i);
    penable <= 1;
    do @(negedge clk_i); while (!pready);
    if (prdata[15:0] !== v)
      report_mismatch($sformatf("ageing_ms readback %0h, wrote %0h", prdata[15:0], v));
    @(posedge clk_i);
    psel <= 0; penable <= 0;
    @(posedge clk_i);
  endtask

  // Result checker: the receiver never stalls, so every strobe is a transaction.
  always @(posedge clk_i) begin
    outcome_t e;
    if (rst_ni && result_valid_o) begin
      if (pending_results.size() == 0) begin
        report_mismatch($sformatf("unexpected result, status %0d", status_o));
      end else begin
        e = pending_results.pop_front();
        n_checked++;
        if (status_o !== e.status)
          report_mismatch($sformatf("status %0d, expected %0d", status_o, e.status));
        if (total_length_o !== e.total_len)
          report_mismatch($sformatf("total_length %0d, expected %0d",
                                    total_length_o, e.total_len));
        if (fragment_count_o !== e.frag_cnt)
          report_mismatch($sformatf("fragment_count %0d, expected %0d",
                                    fragment_count_o, e.frag_cnt));
        if (aged_count_o !== e.aged)
          report_mismatch($sformatf("aged_count %0d, expected %0d", aged_count_o, e.aged));
        case (e.status)
          frt_pkg::ST_REASSEMBLED: n_reassembled++;
          frt_pkg::ST_SUM_FAIL:    n_sum_fail++;
          frt_pkg::ST_TABLE_FULL:  n_full++;
          default: ;
        endcase
        n_aged += e.aged;
      end
    end
  end

  // Keys from a small pool so that fragments meet open contexts.
  function automatic msg_key_t pick_key();
    msg_key_t k;
    case ($urandom_range(0, 3))
      0: k.mtype = 16'h0000;
      1: k.mtype = 16'hFFFF;
      default: k.mtype = 16'($urandom_range(0, 3));
    endcase
    k.mid = ($urandom_range(0, 7) == 0) ? 16'($urandom) : 16'($urandom_range(0, 5));
    case ($urandom_range(0, 3))
      0: k.mac = '0;
      1: k.mac = '1;
      default: k.mac = {32'h0, 16'($urandom_range(0, 2))};
    endcase
    return k;
  endfunction

  function automatic msg_key_t any_key();
    msg_key_t k;
    k.mtype = 16'($urandom);
    k.mid = 16'($urandom);
    k.mac = {16'($urandom), 32'($urandom)};
    return k;
  endfunction

  function automatic logic [10:0] any_len();
    case ($urandom_range(0, 5))
      0: return 11'd0;
      1: return 11'h7FF;
      default: return 11'($urandom);
    endcase
  endfunction

  // -------- tests --------

  task automatic test_directed();
    msg_key_t a, b;
    a = '{16'hFFFF, 16'hFFFF, 48'hFFFF_FFFF_FFFF};
    b = '{16'h0000, 16'h0000, 48'h0};
    send_frag(a, 8'd0, 1'b1, 11'h7FF);      // first fragment that is also last
    send_frag(a, 8'd0, 1'b0, 11'd0);        // open
    send_frag(a, 8'd0, 1'b1, 11'd5);        // repeated first, marked last
    send_frag(a, 8'd1, 1'b0, 11'h7FF);
    send_frag(a, 8'd2, 1'b1, 11'd3);        // sum 3 matches: reassembled
    send_frag(b, 8'd5, 1'b0, 11'd9);        // no first fragment
    send_frag(b, 8'hFF, 1'b1, 11'h7FF);     // no first fragment, last
    send_frag(b, 8'd0, 1'b0, 11'd1);
    send_frag(b, 8'd3, 1'b1, 11'd1);        // sum failure
    send_frag(b, 8'd0, 1'b0, 11'd1);
    send_frag(b, 8'd1, 1'b0, 11'd1);
    send_frag(b, 8'd1, 1'b0, 11'd1);        // repeat is counted again
    send_item(frt_pkg::CMD_TICK, b, 8'd0, 1'b0, 11'd0);
    send_item(frt_pkg::CMD_NONE, a, 8'hFF, 1'b1, 11'h7FF);
    send_item(frt_pkg::CMD_FLUSH, a, 8'd0, 1'b0, 11'd0);
    send_frag(b, 8'd2, 1'b1, 11'd1);        // flushed away: first missing
    drain_results();
  endtask

  task automatic test_table_full();
    msg_key_t k;
    k = '{16'h1234, 16'd0, 48'hABCD};
    for (int i = 0; i <= Slots; i++) begin
      k.mid = 16'(i);
      send_frag(k, 8'd0, 1'b0, 11'd10);     // the last one finds no free slot
    end
    k.mid = 16'd3;
    send_frag(k, 8'd1, 1'b1, 11'd10);       // frees slot 3
    k.mid = 16'd40;
    send_frag(k, 8'd0, 1'b0, 11'd10);       // takes the lowest free slot
    send_item(frt_pkg::CMD_FLUSH, k, 8'd0, 1'b0, 11'd0);
    drain_results();
  endtask

  task automatic test_ageing();
    msg_key_t k;
    set_ageing(16'd1);
    for (int i = 0; i < 3; i++) begin
      k = any_key();
      send_frag(k, 8'd0, 1'b0, 11'd1);
    end
    send_item(frt_pkg::CMD_TICK, k, 8'd0, 1'b0, 11'd0);   // all three age out
    drain_results();
    set_ageing(16'd3);
    send_frag(k, 8'd0, 1'b0, 11'd1);
    send_item(frt_pkg::CMD_TICK, k, 8'd0, 1'b0, 11'd0);
    send_frag(any_key(), 8'd0, 1'b0, 11'd1);
    send_item(frt_pkg::CMD_TICK, k, 8'd0, 1'b0, 11'd0);
    send_item(frt_pkg::CMD_TICK, k, 8'd0, 1'b0, 11'd0);   // first ages out
    send_frag(k, 8'd1, 1'b1, 11'd1);                      // gone: first missing
    send_item(frt_pkg::CMD_TICK, k, 8'd0, 1'b0, 11'd0);
    drain_results();
  endtask

  // Long message: length, count and id sum all saturate.
  task automatic test_saturation();
    msg_key_t k;
    set_ageing(16'hFFFF);
    k = any_key();
    send_frag(k, 8'd0, 1'b0, 11'h7FF);
    for (int i = 0; i < 520; i++)
      send_frag(k, 8'hFF, i == 519, 11'h7FF);
    drain_results();
  endtask

  task automatic random_messages(int budget);
    msg_key_t k;
    int n, sent;
    logic [7:0] fid;
    sent = 0;
    while (sent < budget) begin
      case ($urandom_range(0, 19))
        0, 1: begin
          send_item(frt_pkg::CMD_FRAG, any_key(), 8'($urandom), 1'($urandom), any_len());
          sent++;
        end
        2, 3, 4: begin
          send_item(frt_pkg::CMD_TICK, any_key(), 8'($urandom), 1'($urandom), any_len());
          sent++;
        end
        5: begin
          if ($urandom_range(0, 5) == 0)
            send_item(frt_pkg::CMD_FLUSH, any_key(), 8'($urandom), 1'($urandom),
                      any_len());
          else
            send_item(frt_pkg::CMD_NONE, any_key(), 8'($urandom), 1'($urandom),
                      any_len());
          sent++;
        end
        default: begin
          // well-formed message, sometimes broken by a skip, repeat or lost first
          k = pick_key();
          n = $urandom_range(0, 8);
          if ($urandom_range(0, 7) != 0) begin
            send_frag(k, 8'd0, n == 0, any_len());
            sent++;
          end
          for (int f = 1; f <= n; f++) begin
            fid = 8'(f);
            if ($urandom_range(0, 11) == 0) fid = 8'($urandom_range(1, 255));
            send_frag(k, fid, f == n, any_len());
            sent++;
            if ($urandom_range(0, 4) == 0) begin
              send_item(frt_pkg::CMD_TICK, k, 8'd0, 1'b0, 11'd0);
              sent++;
            end
          end
        end
      endcase
    end
    drain_results();
  endtask

  task automatic test_random_traffic();
    logic [15:0] settings[5];
    settings = '{16'd1, 16'd65535, 16'd7, 16'd25, 16'd1000};
    foreach (settings[i]) begin
      set_ageing(i == 2 ? 16'($urandom_range(2, 40)) : settings[i]);
      random_messages(90);
    end
  endtask

  // Tail of the run with no random idle gaps between transactions.
  task automatic test_back_to_back();
    gaps_on = 0;
    set_ageing(16'd12);
    random_messages(60);
  endtask

  initial begin
    rst_ni = 0;
    start_i = 0; cmd_i = frt_pkg::CMD_FRAG;
    msg_type_i = '0; message_id_i = '0; fragment_id_i = '0; last_flag_i = 0;
    origin_mac_i = '0; frag_len_i = '0;
    psel = 0; penable = 0; pwrite = 0; paddr = '0; pwdata = '0;
    for (int i = 0; i < Slots; i++) ctx_valid[i] = 0;
    clock_ms = 0;
    ageing_ms = 16'd1000;
    repeat (5) @(posedge clk_i);
    rst_ni <= 1;
    @(posedge clk_i);

    test_directed();
    test_table_full();
    test_ageing();
    test_saturation();
    test_random_traffic();
    test_back_to_back();

    $display("Covered %0d transactions (%0d checked): %0d reassembled, %0d sum failures,",
             n_sent, n_checked, n_reassembled, n_sum_fail);
    $display("  %0d table-full rejects, %0d contexts aged out, ageing 1..65535 ms",
             n_full, n_aged);
    if (n_errors == 0 && pending_results.size() == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("%0d mismatches, %0d results never seen", n_errors, pending_results.size());
      $display("Simulation FAILED");
    end
    $finish;
  end

endmodule

// ===== filelist.f =====
src/frt_pkg.sv
src/frt_ram.sv
src/fragment_reassembly_tracker.sv
verif/tb_fragment_reassembly_tracker.sv
